[rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types, constants and the helper function of the Sobel edge magnitude
// block: request and result formats, frame limits, square root step.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned AddrW       = $clog2(MaxWidth);
  localparam int unsigned ColW        = 11;
  localparam int unsigned RowW        = 13;
  localparam int unsigned ResW        = 23;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned MaxRow      = 8191;
  localparam int unsigned ResetWidth  = 640;
  localparam int unsigned ResetHeight = 480;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned SqrtSteps   = 4;
  localparam int unsigned SqrtTopBit  = 14;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] pixel;
  } in_req_t;

  typedef struct packed {
    logic [7:0] edge_res;
    logic       frame_last;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] root;
  } sqrt_t;

  // one digit of the bitwise integer square root
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [15:0] one_v);
    sqrt_t       o;
    logic [16:0] trial;
    trial = {1'b0, s.root} + {1'b0, one_v};
    if ({1'b0, s.rem} >= trial) begin
      o.rem  = s.rem - trial[15:0];
      o.root = (s.root >> 1) + one_v;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[rtl/sobel_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over raster-order grayscale pixels.
//
// Requests enter on in_valid_i/in_req_i and are taken when in_stall_o is low:
// a pixel, or a drain that stands in for the row below the frame. Each taken
// request gives zero or one result on out_valid_o/out_rsp_o; the result of
// the pixel at position p leaves with the request at p + width + 1, and
// width + 1 drains after the last pixel flush the frame, whose final result
// carries frame_last. One request per clock is taken in steady state, when
// no stall holds the pipeline. The rate is set by the single 1024 x 16 line
// buffer, read and written once per request with forwarding between
// back-to-back accesses to one column. For one cycle after a configuration
// write in_stall_o is high while the pixel count of the frame is refreshed.
// When out_stall_i holds a result, the whole pipeline holds and in_stall_o
// rises. Reset sets width 640, height 480, empties the pipeline and starts a
// new frame; the line buffer is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [sem_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire  [sem_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  sem_pkg::in_req_t               in_req_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output sem_pkg::out_rsp_t                    out_rsp_o
);

  typedef struct packed {
    logic [sem_pkg::AddrW-1:0] addr;
    logic [7:0]                val;
    logic                      first;
    logic                      use_above;
    logic                      use_two;
    logic                      emit;
    logic                      last;
  } s1_t;

  // configuration
  logic [sem_pkg::ColW-1:0] w_q;
  logic [sem_pkg::RowW-1:0] h_q;
  logic [sem_pkg::ResW-1:0] wh_q;
  logic                     cfg_hold_q;
  logic [sem_pkg::ColW-1:0] cfg_w;
  logic [sem_pkg::RowW-1:0] cfg_h;
  logic [sem_pkg::ColW+sem_pkg::RowW-1:0] wh_full;

  always_comb begin
    cfg_w = cfg_wdata_i[sem_pkg::ColW-1:0];
    if (cfg_w == '0) begin
      cfg_w = sem_pkg::ColW'(1);
    end else if (cfg_w > sem_pkg::ColW'(sem_pkg::MaxWidth)) begin
      cfg_w = sem_pkg::ColW'(sem_pkg::MaxWidth);
    end
    cfg_h = cfg_wdata_i[sem_pkg::RowW-1:0];
    if (cfg_h == '0) begin
      cfg_h = sem_pkg::RowW'(1);
    end else if (cfg_h > sem_pkg::RowW'(sem_pkg::MaxHeight)) begin
      cfg_h = sem_pkg::RowW'(sem_pkg::MaxHeight);
    end
  end

  assign wh_full = w_q * h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= sem_pkg::ColW'(sem_pkg::ResetWidth);
      h_q        <= sem_pkg::RowW'(sem_pkg::ResetHeight);
      wh_q       <= sem_pkg::ResW'(sem_pkg::ResetWidth * sem_pkg::ResetHeight);
      cfg_hold_q <= 1'b0;
    end else begin
      cfg_hold_q <= cfg_we_i;
      wh_q       <= wh_full[sem_pkg::ResW-1:0];
      if (cfg_we_i) begin
        case (sem_pkg::cfg_idx_e'(cfg_idx_i))
          sem_pkg::CFG_FRAME_WIDTH:  w_q <= cfg_w;
          sem_pkg::CFG_FRAME_HEIGHT: h_q <= cfg_h;
          default: ;
        endcase
      end
    end
  end

  // handshake and pipeline advance
  logic en;
  logic accept;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en || cfg_hold_q;
  assign accept     = in_valid_i && !in_stall_o;

  // stage 0: position tracking
  logic [sem_pkg::ColW-1:0] col_q, c1, c2, col_n;
  logic [sem_pkg::RowW-1:0] row_q, r1, row_n;
  logic [sem_pkg::ResW-1:0] res_q, res_n;
  logic                     drain, ignore, first0, emit0, last0, wrap2;
  logic [7:0]               val0;

  always_comb begin
    c1 = col_q;
    r1 = row_q;
    if (col_q >= w_q) begin
      c1 = '0;
      if (row_q != sem_pkg::RowW'(sem_pkg::MaxRow)) begin
        r1 = row_q + sem_pkg::RowW'(1);
      end
    end
    drain  = in_req_i.op == sem_pkg::OP_DRAIN;
    ignore = drain && (r1 == '0) && (c1 == '0);
    val0   = (drain || (r1 >= h_q)) ? 8'd0 : in_req_i.pixel;
    first0 = c1 == '0;
    emit0  = first0 ? (r1 >= sem_pkg::RowW'(2)) : (r1 >= sem_pkg::RowW'(1));
    c2     = c1 + sem_pkg::ColW'(1);
    wrap2  = c2 >= w_q;
    col_n  = wrap2 ? '0 : c2;
    row_n  = r1;
    if (wrap2 && (r1 != sem_pkg::RowW'(sem_pkg::MaxRow))) begin
      row_n = r1 + sem_pkg::RowW'(1);
    end
    res_n = res_q + sem_pkg::ResW'(emit0);
    last0 = emit0 && (res_n >= wh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      res_q <= '0;
    end else if (accept) begin
      if (ignore) begin
        col_q <= c1;
        row_q <= r1;
      end else if (last0) begin
        col_q <= '0;
        row_q <= '0;
        res_q <= '0;
      end else begin
        col_q <= col_n;
        row_q <= row_n;
        res_q <= res_n;
      end
    end
  end

  // line buffer: {row two above, row above} per column
  logic [15:0]               lbuf [sem_pkg::MaxWidth];
  logic                      rd_en, wr_en, fwd_hit_q;
  logic [sem_pkg::AddrW-1:0] rd_addr;
  logic [15:0]               rd_q, fwd_data_q, wr_data, entry;
  logic                      s1_valid_q;
  s1_t                       s1_q;

  assign rd_en   = accept && !ignore;
  assign rd_addr = c1[sem_pkg::AddrW-1:0];
  assign wr_en   = s1_valid_q && en;
  assign entry   = fwd_hit_q ? fwd_data_q : rd_q;
  assign wr_data = {entry[7:0], s1_q.val};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lbuf[s1_q.addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= lbuf[rd_addr];
      fwd_hit_q  <= wr_en && (s1_q.addr == rd_addr);
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_q.addr      <= rd_addr;
      s1_q.val       <= val0;
      s1_q.first     <= first0;
      s1_q.use_above <= r1 >= sem_pkg::RowW'(1);
      s1_q.use_two   <= r1 >= sem_pkg::RowW'(2);
      s1_q.emit      <= emit0;
      s1_q.last      <= last0;
    end
  end

  // stage 1: window and gradient sums
  logic [7:0]         win_q [9];
  logic [7:0]         mwin  [9];
  logic [7:0]         ncol  [3];
  logic signed [10:0] gx, gy;
  logic signed [10:0] m [9];

  always_comb begin
    ncol[0] = s1_q.use_two   ? entry[15:8] : 8'd0;
    ncol[1] = s1_q.use_above ? entry[7:0]  : 8'd0;
    ncol[2] = s1_q.val;
    for (int r = 0; r < 3; r++) begin
      mwin[r*3]     = win_q[r*3+1];
      mwin[r*3+1]   = win_q[r*3+2];
      mwin[r*3+2]   = s1_q.first ? 8'd0 : ncol[r];
    end
    for (int k = 0; k < 9; k++) begin
      m[k] = signed'({3'b000, mwin[k]});
    end
    gx = m[0] - m[2] + (m[3] <<< 1) - (m[5] <<< 1) + m[6] - m[8];
    gy = m[6] + (m[7] <<< 1) + m[8] - m[0] - (m[1] <<< 1) - m[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        if (s1_q.last) begin
          win_q[r*3]   <= '0;
          win_q[r*3+1] <= '0;
          win_q[r*3+2] <= '0;
        end else begin
          win_q[r*3]   <= s1_q.first ? 8'd0 : win_q[r*3+1];
          win_q[r*3+1] <= s1_q.first ? 8'd0 : win_q[r*3+2];
          win_q[r*3+2] <= ncol[r];
        end
      end
    end
  end

  // stage 2: divide by four toward zero, square
  logic               s2_valid_q, s2_last_q;
  logic signed [10:0] s2_gx_q, s2_gy_q, gx_adj, gy_adj;
  logic signed [8:0]  qx, qy;
  logic signed [17:0] px, py;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_gx_q   <= gx;
      s2_gy_q   <= gy;
      s2_last_q <= s1_q.last;
    end
  end

  assign gx_adj = s2_gx_q + (s2_gx_q[10] ? 11'sd3 : 11'sd0);
  assign gy_adj = s2_gy_q + (s2_gy_q[10] ? 11'sd3 : 11'sd0);
  assign qx     = 9'(gx_adj >>> 2);
  assign qy     = 9'(gy_adj >>> 2);
  assign px     = qx * qx;
  assign py     = qy * qy;

  // stage 3: sum of squares, upper root digits
  logic              s3_valid_q, s3_last_q;
  logic [15:0]       s3_sqx_q, s3_sqy_q;
  logic [16:0]       sum3;
  sem_pkg::sqrt_t    sq3;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sqx_q  <= px[15:0];
      s3_sqy_q  <= py[15:0];
      s3_last_q <= s2_last_q;
    end
  end

  always_comb begin
    sum3     = {1'b0, s3_sqx_q} + {1'b0, s3_sqy_q};
    sq3.rem  = sum3[15:0];
    sq3.root = '0;
    for (int k = 0; k < sem_pkg::SqrtSteps; k++) begin
      sq3 = sem_pkg::sqrt_step(sq3, 16'(16'd1 << (sem_pkg::SqrtTopBit - 2 * k)));
    end
  end

  // stage 4: lower root digits, saturate
  logic           s4_valid_q, s4_last_q, s4_sat_q;
  sem_pkg::sqrt_t s4_sq_q, sq4;
  logic [7:0]     res4;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_sq_q   <= sq3;
      s4_sat_q  <= sum3[16];
      s4_last_q <= s3_last_q;
    end
  end

  always_comb begin
    sq4 = s4_sq_q;
    for (int k = 0; k < sem_pkg::SqrtSteps; k++) begin
      sq4 = sem_pkg::sqrt_step(sq4, 16'(16'd1 << (sem_pkg::SqrtTopBit
                                   - 2 * (k + sem_pkg::SqrtSteps))));
    end
    res4 = s4_sat_q ? 8'd255 : sq4.root[7:0];
  end

  // output register
  sem_pkg::out_rsp_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.edge_res   <= res4;
      out_q.frame_last <= s4_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= rd_en;
      s2_valid_q  <= s1_valid_q && s1_q.emit;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !ignore && last0 |=> col_q == '0 && row_q == '0 && res_q == '0)
    else $error("frame counters not cleared after last result");

  a_drop_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ignore |=> !s1_valid_q)
    else $error("ignored drain entered the pipeline");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("request taken before frame size refresh");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && !en |=> s4_valid_q && $stable(s4_sq_q))
    else $error("last stage lost its result while stalled");

endmodule

`default_nettype wire
